FILE: rtl/tcce_pkg.sv
package tcce_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int TAB_WIDTH   = 8;

    localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(SCREEN_COLS + TAB_WIDTH + 1);
    localparam int ROW_W      = $clog2(SCREEN_ROWS);
    localparam int POS_W      = 11;
    localparam int TAB_STOPS  = SCREEN_COLS / TAB_WIDTH + 1;

    localparam logic [7:0]  RESET_ATTR = 8'h0F;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_TILDE   = 8'h7E;
    localparam logic [7:0]  CH_TAB     = 8'h09;
    localparam logic [7:0]  CH_BS      = 8'h08;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [7:0]  CH_LF      = 8'h0A;
    localparam logic [15:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

    localparam logic KIND_PRINT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef logic [15:0] t_cell;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] row_base;   // row * SCREEN_COLS
    } t_cursor;

    typedef struct packed {
        t_cursor cur;
        logic    wr;        // printable: write the cell at the old cursor
        logic    scroll;    // row passed the bottom
    } t_cur_upd;

    // smallest multiple of TAB_WIDTH above col
    function automatic logic [COL_W-1:0] next_tab(input logic [COL_W-1:0] col);
        logic [COL_W-1:0] res;
        res = '0;
        for (int k = TAB_STOPS; k >= 1; k--) begin
            if (32'(col) < k * TAB_WIDTH) begin
                res = COL_W'(k * TAB_WIDTH);
            end
        end
        return res;
    endfunction

    // fold a sum of two in-range addresses back into the store
    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W:0] s);
        logic [ADDR_W:0] t;
        t = (s >= (ADDR_W+1)'(CELL_COUNT)) ? s - (ADDR_W+1)'(CELL_COUNT) : s;
        return t[ADDR_W-1:0];
    endfunction

endpackage

FILE: rtl/tcce_cursor.sv
module tcce_cursor
    import tcce_pkg::*;
(
    input  logic [7:0] i_char,
    input  t_cursor    i_cur,
    output t_cur_upd   o_upd
);

    logic [COL_W-1:0] col_a;
    logic             lf;
    logic             wr;
    logic             wrap;
    logic             inc;
    logic             last_row;

    always_comb begin
        col_a = i_cur.col;
        lf    = 1'b0;
        wr    = 1'b0;
        unique case (i_char)
            CH_CR: begin
                col_a = '0;
            end
            CH_LF: begin
                col_a = '0;
                lf    = 1'b1;
            end
            CH_TAB: begin
                col_a = next_tab(i_cur.col);
            end
            CH_BS: begin
                if (i_cur.col != '0) begin
                    col_a = i_cur.col - COL_W'(1);
                end
            end
            default: begin
                if (i_char >= CH_SPACE && i_char <= CH_TILDE) begin
                    col_a = i_cur.col + COL_W'(1);
                    wr    = 1'b1;
                end
            end
        endcase
    end

    assign wrap     = (col_a >= COL_W'(SCREEN_COLS));
    assign inc      = lf || wrap;
    assign last_row = (i_cur.row == ROW_W'(SCREEN_ROWS - 1));

    always_comb begin
        o_upd.cur    = i_cur;
        o_upd.cur.col = wrap ? '0 : col_a;
        o_upd.wr     = wr;
        o_upd.scroll = inc && last_row;
        if (inc && !last_row) begin
            o_upd.cur.row      = i_cur.row + ROW_W'(1);
            o_upd.cur.row_base = i_cur.row_base + ADDR_W'(SCREEN_COLS);
        end
    end

endmodule

FILE: rtl/text_console_char_engine_unit.sv
// Text console engine: cursor plus a SCREEN_COLS x SCREEN_ROWS cell store.
// Input channel (i_in_valid / o_in_stall) carries one word per item: a byte
// to print (i_kind = 0) or a cell index to read (i_kind = 1). The output
// channel (o_out_valid / i_out_stall) returns one word per item with the
// cursor position after the item, the cell read (0 for prints) and the
// echoed last-byte flag.
// Cells live in one single-port RAM with a registered read. Scrolling moves
// a base row pointer instead of copying, then blanks the freed row.
// A print result is registered at the accept edge; a read result passes
// the RAM read register, then the output register. One print per cycle
// while the receiver does not stall; a read holds off the next item until
// its result is registered, a scroll until the new bottom row is blanked.
// Reset: cursor home, attribute 0x0F, then a clearing pass writes a white
// on black space into every cell with input stalled. i_cfg_we / i_cfg_wdata
// load the attribute at any time.
// When the receiver stalls, the result word holds in the output register
// and the next item is held off until that word is taken.
module text_console_char_engine_unit
    import tcce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_kind,
    input  logic [7:0]        i_char_code,
    input  logic [10:0]       i_read_cell,
    input  logic              i_last_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [POS_W-1:0]  o_cursor_pos,
    output logic [15:0]       o_read_data,
    output logic              o_write_done
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_BLANK
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_sweep;
    logic [ADDR_W-1:0] r_base;        // physical start of top row
    logic [ADDR_W-1:0] r_blank_base;
    logic [7:0]        r_blank_attr;
    logic [7:0]        r_attr;
    t_cursor           r_cur;
    logic              r_rd_ok;

    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_pos;
    t_cell             r_out_data;
    logic              r_out_done;

    t_cell             mem [CELL_COUNT];
    t_cell             r_rdata;

    t_cur_upd          upd;
    logic              in_acc;
    logic              rc_ok;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    t_cell             mem_wdata;

    tcce_cursor u_cursor (
        .i_char (i_char_code),
        .i_cur  (r_cur),
        .o_upd  (upd)
    );

    assign o_in_stall = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign rc_ok    = (32'(i_read_cell) < CELL_COUNT);
    assign cur_addr = wrap_addr((ADDR_W+1)'(r_cur.row_base) + (ADDR_W+1)'(r_cur.col)
                                + (ADDR_W+1)'(r_base));
    assign rd_addr  = wrap_addr((ADDR_W+1)'(ADDR_W'(i_read_cell)) + (ADDR_W+1)'(r_base));

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = cur_addr;
        mem_wdata = {r_attr, i_char_code};
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_sweep;
                mem_wdata = RESET_CELL;
            end
            ST_BLANK: begin
                mem_we    = 1'b1;
                mem_addr  = r_blank_base + r_sweep;
                mem_wdata = {r_blank_attr, CH_SPACE};
            end
            ST_IDLE: begin
                if (in_acc && i_kind == KIND_PRINT) begin
                    mem_we = upd.wr;
                end else if (in_acc && i_kind == KIND_READ) begin
                    mem_re   = rc_ok;
                    mem_addr = rd_addr;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_sweep     <= '0;
            r_base      <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a print accepted in the same cycle reloads the output word
            if (r_out_valid && !i_out_stall && !(in_acc && i_kind == KIND_PRINT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_sweep <= (r_sweep == ADDR_W'(CELL_COUNT - 1)) ? '0
                                                                    : r_sweep + ADDR_W'(1);
                    if (r_sweep == ADDR_W'(CELL_COUNT - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_out_done <= i_last_byte;
                        if (i_kind == KIND_READ) begin
                            r_rd_ok   <= rc_ok;
                            r_out_pos <= POS_W'(r_cur.row_base + ADDR_W'(r_cur.col));
                            r_state   <= ST_READ;
                        end else begin
                            r_cur       <= upd.cur;
                            r_out_pos   <= POS_W'(upd.cur.row_base + ADDR_W'(upd.cur.col));
                            r_out_data  <= '0;
                            r_out_valid <= 1'b1;
                            if (upd.scroll) begin
                                // old top row becomes the new bottom row
                                r_blank_base <= r_base;
                                r_blank_attr <= r_attr;
                                r_base       <= wrap_addr((ADDR_W+1)'(r_base)
                                                          + (ADDR_W+1)'(SCREEN_COLS));
                                r_sweep      <= '0;
                                r_state      <= ST_BLANK;
                            end
                        end
                    end
                end
                ST_READ: begin
                    r_out_data  <= r_rd_ok ? r_rdata : '0;
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                ST_BLANK: begin
                    r_sweep <= (r_sweep == ADDR_W'(SCREEN_COLS - 1)) ? '0
                                                                     : r_sweep + ADDR_W'(1);
                    if (r_sweep == ADDR_W'(SCREEN_COLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_pos = r_out_pos;
    assign o_read_data  = r_out_data;
    assign o_write_done = r_out_done;

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur.col < COL_W'(SCREEN_COLS) && r_cur.row < ROW_W'(SCREEN_ROWS))
        else $error("cursor out of range");

    a_row_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur.row_base) == 32'(r_cur.row) * SCREEN_COLS)
        else $error("row base out of step with row");

    a_base_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_base) < CELL_COUNT)
        else $error("top row base outside store");

    a_scroll_blanks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == KIND_PRINT && upd.scroll) |=> r_state == ST_BLANK)
        else $error("scroll without blanking pass");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == KIND_READ) |=> ##1 r_out_valid)
        else $error("read result not delivered");

endmodule

FILE: test/text_console_char_engine_unit_test.sv
`timescale 1ns / 1ps

module text_console_char_engine_unit_test;
    import tcce_pkg::*;

    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = SCREEN_COLS + 20;
    localparam int MAX_REPORTS   = 40;

    typedef struct {
        logic        kind;
        logic [7:0]  char_code;
        logic [10:0] read_cell;
        logic        last_byte;
    } console_word_t;

    typedef struct {
        logic [POS_W-1:0] cursor_pos;
        logic [15:0]      read_data;
        logic             write_done;
    } console_reply_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BEAT
    } stall_mode_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [7:0]        i_cfg_wdata = 8'h00;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_kind = KIND_PRINT;
    logic [7:0]        i_char_code = 8'h00;
    logic [10:0]       i_read_cell = 11'd0;
    logic              i_last_byte = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [POS_W-1:0]  o_cursor_pos;
    logic [15:0]       o_read_data;
    logic              o_write_done;

    text_console_char_engine_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_read_cell  (i_read_cell),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cursor_pos (o_cursor_pos),
        .o_read_data  (o_read_data),
        .o_write_done (o_write_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // screen image and cursor as the block should hold them
    t_cell          screen_mem [CELL_COUNT];
    int             cur_col = 0;
    int             cur_row = 0;
    logic [7:0]     cur_attr = RESET_ATTR;

    console_word_t  tx_words [$];
    console_reply_t expected_replies [$];
    console_word_t  drive_word;

    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_prints = 0;
    int n_reads = 0;
    int n_scrolls = 0;
    int n_attrs = 0;
    int n_holds = 0;
    int phase_items = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_trig = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mode_left = 0;
    int beat_cnt = 0;
    stall_mode_t stall_mode = STALL_NONE;

    initial begin
        for (int k = 0; k < CELL_COUNT; k++) screen_mem[k] = RESET_CELL;
    end

    function automatic console_reply_t console_apply(console_word_t w);
        console_reply_t r;
        int             pos;
        r.read_data  = '0;
        r.write_done = w.last_byte;
        if (w.kind == KIND_PRINT) begin
            case (w.char_code)
                CH_CR: cur_col = 0;
                CH_LF: begin
                    cur_col = 0;
                    cur_row++;
                end
                CH_TAB: cur_col = (cur_col / TAB_WIDTH) * TAB_WIDTH + TAB_WIDTH;
                CH_BS: if (cur_col > 0) cur_col--;
                default: begin
                    if (w.char_code >= CH_SPACE && w.char_code <= CH_TILDE) begin
                        screen_mem[cur_row * SCREEN_COLS + cur_col] = {cur_attr, w.char_code};
                        cur_col++;
                        n_prints++;
                    end
                end
            endcase
            if (cur_col >= SCREEN_COLS) begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= SCREEN_ROWS) begin
                for (int k = 0; k < (SCREEN_ROWS - 1) * SCREEN_COLS; k++)
                    screen_mem[k] = screen_mem[k + SCREEN_COLS];
                for (int k = (SCREEN_ROWS - 1) * SCREEN_COLS; k < CELL_COUNT; k++)
                    screen_mem[k] = {cur_attr, CH_SPACE};
                cur_row = SCREEN_ROWS - 1;
                n_scrolls++;
            end
        end else begin
            n_reads++;
            if (w.read_cell < CELL_COUNT) r.read_data = screen_mem[w.read_cell];
        end
        pos = cur_row * SCREEN_COLS + cur_col;
        r.cursor_pos = pos[POS_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // sender: bursts of words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_replies.push_back(console_apply(drive_word));
                n_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (tx_words.size() > 0) begin
                    drive_word = tx_words.pop_front();
                    i_kind      <= drive_word.kind;
                    i_char_code <= drive_word.char_code;
                    i_read_cell <= drive_word.read_cell;
                    i_last_byte <= drive_word.last_byte;
                    i_in_valid  <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern that changes mode now and then, plus long holds
    always @(posedge i_clk) begin
        beat_cnt++;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_trig != hold_seen) begin
            hold_seen = hold_trig;
            hold_left = LONG_HOLD;
            n_holds++;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
                default:     i_out_stall <= (beat_cnt % 5 < 2);
            endcase
        end
    end

    always @(posedge i_clk) begin
        console_reply_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("word with nothing expected", 32'(o_cursor_pos), 32'd0);
            end else begin
                want = expected_replies.pop_front();
                n_checked++;
                if (o_cursor_pos !== want.cursor_pos)
                    report_mismatch("cursor_pos", 32'(o_cursor_pos), 32'(want.cursor_pos));
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", 32'(o_read_data), 32'(want.read_data));
                if (o_write_done !== want.write_done)
                    report_mismatch("write_done", 32'(o_write_done), 32'(want.write_done));
            end
        end
    end

    task automatic queue_item(input logic kind, input logic [7:0] ch,
                              input logic [10:0] cell_idx, input logic last);
        console_word_t w;
        w.kind      = kind;
        w.char_code = ch;
        w.read_cell = cell_idx;
        w.last_byte = last;
        tx_words.push_back(w);
        if (kind == KIND_READ || (ch >= CH_SPACE && ch <= CH_TILDE) || ch == CH_CR
                || ch == CH_LF || ch == CH_TAB || ch == CH_BS)
            phase_items++;
    endtask

    // unused payload fields carry random bits
    task automatic queue_print(input logic [7:0] ch, input logic last);
        queue_item(KIND_PRINT, ch, 11'($urandom_range(0, 2047)), last);
    endtask

    task automatic queue_read(input logic [10:0] cell_idx, input logic last);
        queue_item(KIND_READ, 8'($urandom), cell_idx, last);
    endtask

    function automatic logic [7:0] rand_printable();
        return 8'($urandom_range(CH_SPACE, CH_TILDE));
    endfunction

    task automatic add_sequence();
        int sel;
        int len;
        sel = $urandom_range(0, 19);
        if (sel < 8) begin
            len = $urandom_range(0, 12);
            for (int k = 0; k < len; k++) queue_print(rand_printable(), 1'b0);
            if ($urandom_range(0, 1)) queue_print(CH_CR, 1'b0);
            queue_print(CH_LF, 1'b1);
        end else if (sel < 10) begin
            len = $urandom_range(60, 120);
            for (int k = 0; k < len; k++) queue_print(rand_printable(), k == len - 1);
        end else if (sel < 12) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 2) == 0) queue_print(rand_printable(), 1'b0);
                queue_print(CH_TAB, k == len - 1);
            end
        end else if (sel < 14) begin
            len = $urandom_range(0, 5);
            for (int k = 0; k < len; k++) queue_print(rand_printable(), 1'b0);
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++) queue_print(CH_BS, k == len - 1);
        end else if (sel < 17) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0)
                    queue_read(11'($urandom_range(CELL_COUNT, 2047)), 1'($urandom));
                else
                    queue_read(11'($urandom_range(0, CELL_COUNT - 1)), 1'($urandom));
            end
        end else if (sel < 18) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) queue_print(8'($urandom), 1'($urandom));
        end else begin
            queue_item(1'($urandom), 8'($urandom), 11'($urandom), 1'($urandom));
        end
    endtask

    task automatic fill_random(input int target);
        phase_items = 0;
        while (phase_items < target) add_sequence();
    endtask

    task automatic wait_idle();
        while (tx_words.size() != 0 || i_in_valid || expected_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // a scroll may still be blanking the bottom row after its word is out
    task automatic set_attr(input logic [7:0] value);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_attr = value;
        n_attrs++;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_read(11'd0, 1'b0);
        queue_read(11'd1999, 1'b0);
        queue_read(11'd2047, 1'b1);
        queue_read(11'd2000, 1'b0);
        queue_print(CH_SPACE, 1'b0);
        queue_print(CH_TILDE, 1'b0);
        queue_print(8'h1F, 1'b0);
        queue_print(8'h7F, 1'b0);
        queue_print(8'hFF, 1'b0);
        queue_print(8'h00, 1'b1);
        queue_print(CH_BS, 1'b0);
        queue_print(CH_CR, 1'b0);
        queue_print(CH_BS, 1'b0);            // clamps at column 0
        queue_print(CH_TAB, 1'b0);
        queue_print("A", 1'b0);
        queue_print(CH_TAB, 1'b0);
        queue_print(CH_LF, 1'b1);
        queue_read(11'd0, 1'b0);
        queue_read(11'd1, 1'b0);
        queue_read(11'd8, 1'b0);
        queue_print("Z", 1'b1);
        queue_read(11'(SCREEN_COLS), 1'b1);
        wait_idle();

        // receiver holds off while the sender keeps offering
        set_attr(8'h00);
        fill_random(100);
        hold_trig <= hold_trig + 1;

        set_attr(8'hFF);
        fill_random(100);

        set_attr(8'($urandom));
        for (int k = 0; k < SCREEN_ROWS; k++) queue_print(CH_LF, k == SCREEN_ROWS - 1);
        fill_random(100);

        set_attr(8'($urandom));
        fill_random(100);

        set_attr(RESET_ATTR);
        fill_random(100);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d words, %0d checked: %0d printable, %0d reads, %0d scrolls",
                 n_sent, n_checked, n_prints, n_reads, n_scrolls);
        $display("with %0d attribute writes and %0d long receiver holds", n_attrs, n_holds);
        if (errors == 0) begin
            $display("text_console_char_engine_unit: match");
        end else begin
            $display("text_console_char_engine_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d words still expected", expected_replies.size());
        $display("text_console_char_engine_unit: mismatch");
        $finish;
    end

endmodule

FILE: text_console_char_engine_unit.f
rtl/tcce_pkg.sv
rtl/tcce_cursor.sv
rtl/text_console_char_engine_unit.sv
test/text_console_char_engine_unit_test.sv
